### rtl/wpp_pkg.sv
// Shared constants, tables and types for the world point perspective projection block.
package wpp_pkg;

	localparam int SCREEN_WIDTH  = 1920;
	localparam int SCREEN_HEIGHT = 1080;
	localparam int HALF_W        = SCREEN_WIDTH / 2;
	localparam int HALF_H        = SCREEN_HEIGHT / 2;
	localparam int HALF_BITS     = 13;

	localparam int CORDIC_STEPS = 18;
	localparam int CW           = 34;
	localparam int AXW          = 18;
	localparam int DW           = 25;
	localparam int PW           = DW + AXW;
	localparam int SW           = PW + 2;
	localparam int CAMW         = SW - 14;
	localparam int MAGW         = CAMW + HALF_BITS;
	localparam int DENW         = CAMW + 16;
	localparam int QW           = 18;
	localparam int DIV_W        = 68;
	localparam int NSTG         = 6 + QW;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
		34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
		34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
		34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
		34'sh000028BE, 34'sh0000145F
	};

	localparam logic [2:0] REG_EYE_X = 3'd0;
	localparam logic [2:0] REG_EYE_Y = 3'd1;
	localparam logic [2:0] REG_EYE_Z = 3'd2;
	localparam logic [2:0] REG_PITCH = 3'd3;
	localparam logic [2:0] REG_YAW   = 3'd4;
	localparam logic [2:0] REG_ROLL  = 3'd5;
	localparam logic [2:0] REG_FOV_X = 3'd6;
	localparam logic [2:0] REG_FOV_Y = 3'd7;

	typedef struct packed {
		logic signed [AXW-1:0] fx;
		logic signed [AXW-1:0] fy;
		logic signed [AXW-1:0] fz;
		logic signed [AXW-1:0] rx;
		logic signed [AXW-1:0] ry;
		logic signed [AXW-1:0] rz;
		logic signed [AXW-1:0] ux;
		logic signed [AXW-1:0] uy;
		logic signed [AXW-1:0] uz;
		logic                  ready;
	} axes_t;

endpackage

### rtl/wpp_axes.sv
// Camera axis sequencer: shared CORDIC for the three angles, then axis products.
module wpp_axes import wpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] pitch,
	input  logic [15:0] yaw,
	input  logic [15:0] roll,
	output axes_t       axes
);

	localparam logic [2:0] SQ_INIT  = 3'd0;
	localparam logic [2:0] SQ_ITER  = 3'd1;
	localparam logic [2:0] SQ_STORE = 3'd2;
	localparam logic [2:0] SQ_AXES  = 3'd3;
	localparam logic [2:0] SQ_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] ang_q;
	logic [4:0] step_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic neg_q;
	logic signed [AXW-1:0] sp_q, cp_q, sy_q, cy_q, sr_q, cr_q, t1_q, t2_q;
	logic signed [AXW-1:0] fx_q, fy_q, rx_q, ry_q, rz_q, ux_q, uy_q, uz_q;

	logic [15:0] ang_sel;
	logic signed [16:0] a_raw, a_fold;
	logic fold_neg;
	logic signed [CW-1:0] z_init, xs, ys, xr, yr;
	logic signed [AXW-1:0] xrnd, yrnd, sn, cs;
	logic signed [AXW:0] a1, b1, a2, b2;
	logic signed [2*AXW+2:0] mac, macr;
	logic signed [AXW-1:0] mac_res;

	always_comb begin
		unique case (ang_q)
			2'd0:    ang_sel = pitch;
			2'd1:    ang_sel = yaw;
			default: ang_sel = roll;
		endcase
		a_raw = {ang_sel[15], ang_sel};
		fold_neg = 1'b0;
		a_fold = a_raw;
		if (a_raw > 17'sd16384) begin
			a_fold = a_raw - 17'sd32768;
			fold_neg = 1'b1;
		end else if (a_raw < -17'sd16384) begin
			a_fold = a_raw + 17'sd32768;
			fold_neg = 1'b1;
		end
		z_init = {{(CW-33){a_fold[16]}}, a_fold, 16'b0};
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		xr = x_q + CW'(32768);
		yr = y_q + CW'(32768);
		xrnd = xr[CW-1:16];
		yrnd = yr[CW-1:16];
		sn = neg_q ? -yrnd : yrnd;
		cs = neg_q ? -xrnd : xrnd;
	end

	function automatic logic signed [AXW:0] ext(input logic signed [AXW-1:0] v);
		return {v[AXW-1], v};
	endfunction

	always_comb begin
		a1 = '0; b1 = '0; a2 = '0; b2 = '0;
		unique case (step_q)
			5'd0: begin a1 = ext(sp_q); b1 = ext(cy_q); end
			5'd1: begin a1 = ext(sp_q); b1 = ext(sy_q); end
			5'd2: begin a1 = ext(cp_q); b1 = ext(cy_q); end
			5'd3: begin a1 = ext(cp_q); b1 = ext(sy_q); end
			5'd4: begin
				a1 = ext(cr_q); b1 = ext(sy_q); a2 = -ext(sr_q); b2 = ext(t1_q);
			end
			5'd5: begin
				a1 = -ext(cr_q); b1 = ext(cy_q); a2 = -ext(sr_q); b2 = ext(t2_q);
			end
			5'd6: begin a1 = -ext(sr_q); b1 = ext(cp_q); end
			5'd7: begin
				a1 = ext(sr_q); b1 = ext(sy_q); a2 = ext(cr_q); b2 = ext(t1_q);
			end
			5'd8: begin
				a1 = ext(cr_q); b1 = ext(t2_q); a2 = -ext(sr_q); b2 = ext(cy_q);
			end
			5'd9: begin a1 = ext(cr_q); b1 = ext(cp_q); end
			default: begin a1 = '0; end
		endcase
		mac = a1 * b1 + a2 * b2;
		macr = mac + (2*AXW+3)'(8192);
		mac_res = macr[AXW+13:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_INIT;
			ang_q <= 2'd0;
			step_q <= 5'd0;
		end else if (start) begin
			state_q <= SQ_INIT;
			ang_q <= 2'd0;
			step_q <= 5'd0;
		end else begin
			unique case (state_q)
				SQ_INIT: begin
					step_q <= 5'd0;
					state_q <= SQ_ITER;
				end
				SQ_ITER: begin
					if (step_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= SQ_STORE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				SQ_STORE: begin
					step_q <= 5'd0;
					if (ang_q == 2'd2) begin
						state_q <= SQ_AXES;
					end else begin
						ang_q <= ang_q + 2'd1;
						state_q <= SQ_INIT;
					end
				end
				SQ_AXES: begin
					if (step_q == 5'd9) begin
						state_q <= SQ_DONE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= SQ_DONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_INIT) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z_init;
			neg_q <= fold_neg;
		end
		if (state_q == SQ_ITER) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ATAN_TAB[step_q];
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ATAN_TAB[step_q];
			end
		end
		if (state_q == SQ_STORE) begin
			unique case (ang_q)
				2'd0:    begin sp_q <= sn; cp_q <= cs; end
				2'd1:    begin sy_q <= sn; cy_q <= cs; end
				default: begin sr_q <= sn; cr_q <= cs; end
			endcase
		end
		if (state_q == SQ_AXES) begin
			unique case (step_q)
				5'd0:    t1_q <= mac_res;
				5'd1:    t2_q <= mac_res;
				5'd2:    fx_q <= mac_res;
				5'd3:    fy_q <= mac_res;
				5'd4:    rx_q <= mac_res;
				5'd5:    ry_q <= mac_res;
				5'd6:    rz_q <= mac_res;
				5'd7:    ux_q <= mac_res;
				5'd8:    uy_q <= mac_res;
				default: uz_q <= mac_res;
			endcase
		end
	end

	assign axes.fx = fx_q;
	assign axes.fy = fy_q;
	assign axes.fz = -sp_q;
	assign axes.rx = rx_q;
	assign axes.ry = ry_q;
	assign axes.rz = rz_q;
	assign axes.ux = ux_q;
	assign axes.uy = uy_q;
	assign axes.uz = uz_q;
	assign axes.ready = (state_q == SQ_DONE);

endmodule

### rtl/world_point_perspective_projection_top.sv
// Top level of the world point perspective projection pipeline.
//
// channel  direction  handshake             payload
// config   in         wr_en                 wr_index, wr_data
// point    in         in_valid / in_stall   point_x, point_y, point_z
// pixel    out        out_valid / out_stall screen_x, screen_y, visible
//
// One point per cycle while in_stall is low; 18 of the pipeline stages form the
// bit-per-stage quotient pipeline. After reset and after each register write
// the axis sequencer runs three CORDIC passes, then ten multiply steps, with
// in_stall high. Each stage moves when the next one has
// room, so bubbles collapse under out_stall and no transaction is lost.
module world_point_perspective_projection_top import wpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [23:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] screen_x,
	output logic signed [15:0] screen_y,
	output logic               visible
);

	logic signed [23:0] eye_x_q, eye_y_q, eye_z_q;
	logic [15:0] pitch_q, yaw_q, roll_q, fov_x_q, fov_y_q;
	axes_t ax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0;
			eye_y_q <= '0;
			eye_z_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			roll_q <= '0;
			fov_x_q <= 16'd16384;
			fov_y_q <= 16'd16384;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EYE_X: eye_x_q <= wr_data;
				REG_EYE_Y: eye_y_q <= wr_data;
				REG_EYE_Z: eye_z_q <= wr_data;
				REG_PITCH: pitch_q <= wr_data[15:0];
				REG_YAW:   yaw_q <= wr_data[15:0];
				REG_ROLL:  roll_q <= wr_data[15:0];
				REG_FOV_X: fov_x_q <= wr_data[15:0];
				REG_FOV_Y: fov_y_q <= wr_data[15:0];
			endcase
		end
	end

	wpp_axes u_axes (
		.clk   (clk),
		.arst_n(arst_n),
		.start (wr_en),
		.pitch (pitch_q),
		.yaw   (yaw_q),
		.roll  (roll_q),
		.axes  (ax)
	);

	// stage handshake
	logic [NSTG:1] vld_q;
	logic [NSTG:1] rdy;
	logic acc;

	assign rdy[NSTG] = !vld_q[NSTG] || !out_stall;
	for (genvar k = 1; k < NSTG; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign in_stall = !rdy[1] || !ax.ready;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= acc;
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// s1: offset from eye
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dx_s1 <= DW'(point_x) - DW'(eye_x_q);
			dy_s1 <= DW'(point_y) - DW'(eye_y_q);
			dz_s1 <= DW'(point_z) - DW'(eye_z_q);
		end
	end

	// s2: nine products
	logic signed [PW-1:0] prx_s2, pry_s2, prz_s2, pux_s2, puy_s2, puz_s2;
	logic signed [PW-1:0] pfx_s2, pfy_s2, pfz_s2;
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			prx_s2 <= dx_s1 * ax.rx;
			pry_s2 <= dy_s1 * ax.ry;
			prz_s2 <= dz_s1 * ax.rz;
			pux_s2 <= dx_s1 * ax.ux;
			puy_s2 <= dy_s1 * ax.uy;
			puz_s2 <= dz_s1 * ax.uz;
			pfx_s2 <= dx_s1 * ax.fx;
			pfy_s2 <= dy_s1 * ax.fy;
			pfz_s2 <= dz_s1 * ax.fz;
		end
	end

	// s3: dot products, rounded to Q8
	logic signed [SW-1:0] sumx, sumy, sumz;
	logic signed [CAMW-1:0] camx_s3, camy_s3, camz_s3;
	logic vis_s3;
	always_comb begin
		sumx = SW'(prx_s2) + SW'(pry_s2) + SW'(prz_s2) + SW'(8192);
		sumy = SW'(pux_s2) + SW'(puy_s2) + SW'(puz_s2) + SW'(8192);
		sumz = SW'(pfx_s2) + SW'(pfy_s2) + SW'(pfz_s2) + SW'(8192);
	end
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			camx_s3 <= sumx[SW-1:14];
			camy_s3 <= sumy[SW-1:14];
			camz_s3 <= sumz[SW-1:14];
			vis_s3 <= ($signed(sumz[SW-1:14]) >= $signed(CAMW'(256)));
		end
	end

	// s4: numerator magnitude and denominator
	logic [CAMW-1:0] absx, absy;
	logic [15:0] fx_eff, fy_eff;
	logic [MAGW-1:0] magx_s4, magy_s4;
	logic [DENW-1:0] denx_s4, deny_s4;
	logic negx_s4, negy_s4, vis_s4;
	always_comb begin
		absx = camx_s3[CAMW-1] ? CAMW'(-camx_s3) : CAMW'(camx_s3);
		absy = camy_s3[CAMW-1] ? CAMW'(-camy_s3) : CAMW'(camy_s3);
		fx_eff = (fov_x_q == 16'd0) ? 16'd1 : fov_x_q;
		fy_eff = (fov_y_q == 16'd0) ? 16'd1 : fov_y_q;
	end
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			magx_s4 <= MAGW'(absx) * MAGW'(HALF_W);
			magy_s4 <= MAGW'(absy) * MAGW'(HALF_H);
			denx_s4 <= DENW'(camz_s3) * DENW'(fx_eff);
			deny_s4 <= DENW'(camz_s3) * DENW'(fy_eff);
			negx_s4 <= camx_s3[CAMW-1];
			negy_s4 <= camy_s3[CAMW-1];
			vis_s4 <= vis_s3;
		end
	end

	// s5 and quotient stages: index 0 is s5
	logic [DIV_W-1:0] remx_sd [QW+1];
	logic [DIV_W-1:0] remy_sd [QW+1];
	logic [DIV_W-1:0] dvx_sd [QW+1];
	logic [DIV_W-1:0] dvy_sd [QW+1];
	logic [QW-1:0] qx_sd [QW+1];
	logic [QW-1:0] qy_sd [QW+1];
	logic [QW:0] ovfx_sd, ovfy_sd, negx_sd, negy_sd, vis_sd;

	logic [DIV_W-1:0] nx, ny, ddx, ddy;
	always_comb begin
		nx = (DIV_W'(magx_s4) << 15) + DIV_W'(denx_s4);
		ny = (DIV_W'(magy_s4) << 15) + DIV_W'(deny_s4);
		ddx = DIV_W'(denx_s4) << 1;
		ddy = DIV_W'(deny_s4) << 1;
	end
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			remx_sd[0] <= nx;
			remy_sd[0] <= ny;
			dvx_sd[0] <= ddx;
			dvy_sd[0] <= ddy;
			qx_sd[0] <= '0;
			qy_sd[0] <= '0;
			ovfx_sd[0] <= (nx >= (ddx << QW));
			ovfy_sd[0] <= (ny >= (ddy << QW));
			negx_sd[0] <= negx_s4;
			negy_sd[0] <= negy_s4;
			vis_sd[0] <= vis_s4;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic [DIV_W-1:0] trx, try_;
		assign trx = dvx_sd[j-1] << (QW - j);
		assign try_ = dvy_sd[j-1] << (QW - j);
		always_ff @(posedge clk) begin
			if (rdy[5+j]) begin
				if (remx_sd[j-1] >= trx) begin
					remx_sd[j] <= remx_sd[j-1] - trx;
					qx_sd[j] <= qx_sd[j-1] | (QW'(1) << (QW - j));
				end else begin
					remx_sd[j] <= remx_sd[j-1];
					qx_sd[j] <= qx_sd[j-1];
				end
				if (remy_sd[j-1] >= try_) begin
					remy_sd[j] <= remy_sd[j-1] - try_;
					qy_sd[j] <= qy_sd[j-1] | (QW'(1) << (QW - j));
				end else begin
					remy_sd[j] <= remy_sd[j-1];
					qy_sd[j] <= qy_sd[j-1];
				end
				dvx_sd[j] <= dvx_sd[j-1];
				dvy_sd[j] <= dvy_sd[j-1];
				ovfx_sd[j] <= ovfx_sd[j-1];
				ovfy_sd[j] <= ovfy_sd[j-1];
				negx_sd[j] <= negx_sd[j-1];
				negy_sd[j] <= negy_sd[j-1];
				vis_sd[j] <= vis_sd[j-1];
			end
		end
	end

	// output stage: center, sign, saturate, zero when not visible
	function automatic logic signed [15:0] sat16(input logic signed [QW+2:0] v);
		if (v > (QW+3)'(32767)) return 16'sh7FFF;
		if (v < -(QW+3)'(32768)) return 16'sh8000;
		return v[15:0];
	endfunction

	logic [QW:0] qsx, qsy;
	logic signed [QW+2:0] svx, svy, vx, vy;
	always_comb begin
		qsx = ovfx_sd[QW] ? ((QW+1)'(1) << QW) : {1'b0, qx_sd[QW]};
		qsy = ovfy_sd[QW] ? ((QW+1)'(1) << QW) : {1'b0, qy_sd[QW]};
		svx = negx_sd[QW] ? -(QW+3)'(qsx) : (QW+3)'(qsx);
		svy = negy_sd[QW] ? -(QW+3)'(qsy) : (QW+3)'(qsy);
		vx = (QW+3)'(HALF_W) + svx;
		vy = (QW+3)'(HALF_H) - svy;
	end

	logic signed [15:0] sx_so, sy_so;
	logic vis_so;
	always_ff @(posedge clk) begin
		if (rdy[NSTG]) begin
			sx_so <= vis_sd[QW] ? sat16(vx) : 16'sd0;
			sy_so <= vis_sd[QW] ? sat16(vy) : 16'sd0;
			vis_so <= vis_sd[QW];
		end
	end

	assign out_valid = vld_q[NSTG];
	assign screen_x = sx_so;
	assign screen_y = sy_so;
	assign visible = vis_so;

endmodule
